@@ rtl/nfc_pkg.sv @@
`default_nettype none
package nfc_pkg;

	localparam int unsigned W = 64;

	typedef enum logic [2:0] {
		K_INT   = 3'd0,
		K_RAT   = 3'd1,
		K_DBL   = 3'd2,
		K_CPLX  = 3'd3,
		K_NONUM = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_NAN   = 3'd1,
		ST_INF   = 3'd2,
		ST_BIG   = 3'd3,
		ST_CPLX  = 3'd4,
		ST_NONUM = 3'd5
	} status_t;

	typedef struct packed {
		logic        op;
		logic [2:0]  kind;
		logic [63:0] numerator;
		logic [62:0] denominator;
		logic [63:0] real_bits;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] result;
		logic [2:0]  status;
	} out_beat_t;

	// Data handed from one divider cell to the next.
	typedef struct packed {
		logic        vld;
		logic        ceil_m;
		logic        neg;
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] dvd;
		logic [62:0] den;
		logic        bypass;
		logic [63:0] bres;
		logic [2:0]  bst;
	} cell_t;

endpackage
`default_nettype wire

@@ rtl/nfc_cell.sv @@
`default_nettype none
module nfc_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire nfc_pkg::cell_t d,
	output nfc_pkg::cell_t      q
);
	import nfc_pkg::*;

	logic [64:0] trial;
	logic [63:0] rsh;
	logic        fits;
	logic        vld_q;
	cell_t       pay_q;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rsh   = {d.rem[62:0], d.dvd[63]};
		trial = {1'b0, rsh} - {2'b00, d.den};
		fits  = ~trial[64] | d.rem[63];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q.vld    <= d.vld;
		pay_q.ceil_m <= d.ceil_m;
		pay_q.neg    <= d.neg;
		pay_q.rem    <= fits ? trial[63:0] : rsh;
		pay_q.quo    <= {d.quo[62:0], fits};
		pay_q.dvd    <= {d.dvd[62:0], 1'b0};
		pay_q.den    <= d.den;
		pay_q.bypass <= d.bypass;
		pay_q.bres   <= d.bres;
		pay_q.bst    <= d.bst;
	end

	// The valid bit comes from the reset flop; the payload is not reset.
	always_comb begin
		q     = pay_q;
		q.vld = vld_q;
	end
endmodule
`default_nettype wire

@@ rtl/nfc_front.sv @@
`default_nettype none
module nfc_front (
	input  wire logic             start,
	input  wire nfc_pkg::in_beat_t din,
	output nfc_pkg::cell_t        c
);
	import nfc_pkg::*;

	logic        neg, dneg, frac;
	logic [10:0] ex;
	logic [51:0] man;
	logic [52:0] sig;
	logic [63:0] ip, mask, r;
	logic [2:0]  st;

	always_comb begin
		neg  = din.numerator[63];
		dneg = din.real_bits[63];
		ex   = din.real_bits[62:52];
		man  = din.real_bits[51:0];
		sig  = {1'b1, man};
		ip   = '0;
		frac = 1'b0;
		mask = '0;
		if (ex < 11'd1023) begin
			frac = (ex != 0) || (man != 0);
		end else if (ex >= 11'd1075) begin
			ip = {11'd0, sig} << (ex - 11'd1075);
		end else begin
			mask = ~(64'hFFFF_FFFF_FFFF_FFFF << (11'd1075 - ex));
			ip   = {11'd0, sig} >> (11'd1075 - ex);
			frac = ({11'd0, sig} & mask) != 0;
		end
		r  = dneg ? (64'd0 - (ip + {63'd0, ~din.op & frac}))
		          : (ip + {63'd0, din.op & frac});
		st = ST_OK;
		if (ex == 11'h7FF)
			st = (man != 0) ? ST_NAN : ST_INF;
		else if (ex >= 11'd1086) begin
			if (dneg && ex == 11'd1086 && man == 0)
				r = 64'h8000_0000_0000_0000;
			else
				st = ST_BIG;
		end
		c.vld    = start;
		c.ceil_m = din.op;
		c.neg    = neg;
		c.rem    = '0;
		c.quo    = '0;
		c.dvd    = neg ? 64'd0 - din.numerator : din.numerator;
		c.den    = (din.denominator == 0) ? 63'd1 : din.denominator;
		c.bypass = 1'b1;
		c.bres   = '0;
		c.bst    = ST_OK;
		case (din.kind)
			K_INT: c.bres = din.numerator;
			K_RAT: c.bypass = 1'b0;
			K_DBL: begin
				c.bst  = st;
				c.bres = (st == ST_OK) ? r : 64'd0;
			end
			K_CPLX:  c.bst = ST_CPLX;
			default: c.bst = ST_NONUM;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/number_floor_ceiling_unit.sv @@
`default_nettype none
// A beat accepted with start reaches done after passing through all registers on its path
// (64 divider cells plus the output register).
// Throughput: one beat per cycle; busy is held low, since the chain of cells never stalls.
// The 64 restoring-division cells set the latency, one quotient bit per cell.
// Reset clears the valid bits of every cell and the done strobe; payloads are not reset.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module number_floor_ceiling_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire nfc_pkg::in_beat_t din,
	output logic                   done,
	output nfc_pkg::out_beat_t     dout
);
	import nfc_pkg::*;

	cell_t chain [0:W];
	logic  step;
	logic [63:0] rr;

	// Decode and the double rounding happen in front of the chain; the
	// rational divides as the beat walks down the cells.
	nfc_front u_front (.start(start & ~busy), .din(din), .c(chain[0]));

	for (genvar i = 0; i < W; i++) begin : g_cell
		nfc_cell u_cell (.clk(clk), .arst_n(arst_n), .d(chain[i]), .q(chain[i+1]));
	end

	always_comb begin
		step = chain[W].ceil_m ^ chain[W].neg;
		rr   = chain[W].quo + {63'd0, step && chain[W].rem != 0};
		if (chain[W].neg)
			rr = 64'd0 - rr;
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain[W].vld;
		end
	end

	always_ff @(posedge clk) begin
		dout.result <= chain[W].bypass ? chain[W].bres : rr;
		dout.status <= chain[W].bypass ? chain[W].bst : ST_OK;
	end
endmodule
`default_nettype wire
